// ===== design/dxt_pkg.sv =====
// ----------------------------------------------------------------------------
// dxt_pkg
// Shared types, format codes and constant-divide helpers for the S3TC
// block decoder.
// ----------------------------------------------------------------------------
package dxt_pkg;

  localparam logic [1:0] FMT_DXT1 = 2'd0;
  localparam logic [1:0] FMT_DXT3 = 2'd1;
  localparam logic [1:0] FMT_DXT5 = 2'd2;

  typedef logic [7:0]      chan_t;
  // index 0 is R, 1 is G, 2 is B
  typedef logic [2:0][7:0] rgb_t;

  // c*255/31 = 8*c + floor(7*c/31); 7*c/31 by reciprocal 265/2^13
  function automatic chan_t expand5(input logic [4:0] c);
    logic [7:0]  n;
    logic [16:0] q;
    n = 8'(c) * 8'd7;
    q = 17'(n) * 17'd265;
    return {c, 3'b000} + {5'b00000, q[15:13]};
  endfunction

  // c*255/63 = 4*c + floor(c/21); c/21 by reciprocal 49/2^10
  function automatic chan_t expand6(input logic [5:0] c);
    logic [11:0] q;
    q = 12'(c) * 12'd49;
    return {c, 2'b00} + {6'b000000, q[11:10]};
  endfunction

  // floor(n/3) for n < 768
  function automatic chan_t div3(input logic [9:0] n);
    logic [19:0] p;
    p = 20'(n) * 20'd683;
    return p[18:11];
  endfunction

  // floor(n/7) for n < 1792
  function automatic chan_t div7(input logic [10:0] n);
    logic [21:0] p;
    p = 22'(n) * 22'd2341;
    return p[21:14];
  endfunction

  // floor(n/5) for n < 1280
  function automatic chan_t div5(input logic [10:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'd1639;
    return p[20:13];
  endfunction

endpackage

// ===== design/dxt_if.sv =====
// ----------------------------------------------------------------------------
// dxt channel interfaces
// Valid/ready channels for the compressed block input, the pixel row
// output and the format register write port.
// ----------------------------------------------------------------------------
interface dxt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] alpha_word;
  logic [63:0] color_word;
  modport source (output valid, alpha_word, color_word, input ready);
  modport sink   (input valid, alpha_word, color_word, output ready);
endinterface

interface dxt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  row_index;
  logic [31:0] pixel_a;
  logic [31:0] pixel_b;
  logic [31:0] pixel_c;
  logic [31:0] pixel_d;
  logic        last_row;
  modport source (output valid, row_index, pixel_a, pixel_b, pixel_c, pixel_d,
                  last_row, input ready);
  modport sink   (input valid, row_index, pixel_a, pixel_b, pixel_c, pixel_d,
                  last_row, output ready);
endinterface

interface dxt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== design/dxt_block_decoder_top.sv =====
// ----------------------------------------------------------------------------
// dxt_block_decoder_top
// S3TC (DXT1/DXT3/DXT5) 4x4 block decoder, one RGBA8888 pixel row per beat.
//
//   channel  dir  beat payload                          handshake
//   cfg_ch   in   data: block format (0 DXT1,1 DXT3,2 DXT5) valid/ready
//   in_ch    in   alpha_word, color_word (one block)    valid/ready
//   out_ch   out  row_index, pixel_a..d, last_row       valid/ready
//
// The row stage holds a block while it emits its four rows, one per cycle
// while the output is not stalled, and takes the next block as its last row
// leaves. Row 0 passes through the endpoint register, palette register and
// output register in turn. rst_n (synchronous) clears all valid flags and
// sets the format to DXT1. A stalled output holds the row stage; the endpoint
// register keeps taking one more block behind it.
// ----------------------------------------------------------------------------
module dxt_block_decoder_top
  import dxt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dxt_cfg_if.sink   cfg_ch,
  dxt_in_if.sink    in_ch,
  dxt_out_if.source out_ch
);

  // format register
  logic [1:0] fmt_r;

  // endpoint stage
  logic        s1_vld_r;
  rgb_t        s1_e0_r, s1_e1_r;
  logic        s1_four_r;
  logic [31:0] s1_cidx_r;
  logic [63:0] s1_aw_r;
  rgb_t        e0_nxt, e1_nxt;

  // palette / row stage
  logic        s2_vld_r;
  logic [1:0]  s2_row_r;
  logic [31:0] s2_cpal_r [4];
  chan_t       s2_apal_r [8];
  logic [31:0] s2_cidx_r;
  logic [63:0] s2_aw_r;
  logic [31:0] cpal_nxt [4];
  chan_t       apal_nxt [8];

  // output register
  logic        o_vld_r;
  logic [1:0]  o_row_r;
  logic [31:0] o_pix_r [4];
  logic        o_last_r;
  logic [31:0] pix_nxt [4];

  logic s1_take, s2_load, s2_done, out_load;

  // ---------------------------------------------------------------- control
  assign out_load    = s2_vld_r && (!o_vld_r || out_ch.ready);
  assign s2_done     = out_load && (s2_row_r == 2'd3);
  assign s2_load     = s1_vld_r && (!s2_vld_r || s2_done);
  assign in_ch.ready = !s1_vld_r || s2_load;
  assign s1_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r    <= FMT_DXT1;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s2_row_r <= 2'd0;
      o_vld_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        fmt_r <= cfg_ch.data;
      end
      if (s1_take) begin
        s1_vld_r <= 1'b1;
      end else if (s2_load) begin
        s1_vld_r <= 1'b0;
      end
      if (s2_load) begin
        s2_vld_r <= 1'b1;
        s2_row_r <= 2'd0;
      end else if (out_load) begin
        s2_vld_r <= !s2_done;
        s2_row_r <= s2_row_r + 2'd1;
      end
      if (out_load) begin
        o_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        o_vld_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------- endpoint stage
  always_comb begin
    e0_nxt[0] = expand5(in_ch.color_word[15:11]);
    e0_nxt[1] = expand6(in_ch.color_word[10:5]);
    e0_nxt[2] = expand5(in_ch.color_word[4:0]);
    e1_nxt[0] = expand5(in_ch.color_word[31:27]);
    e1_nxt[1] = expand6(in_ch.color_word[26:21]);
    e1_nxt[2] = expand5(in_ch.color_word[20:16]);
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_e0_r   <= e0_nxt;
      s1_e1_r   <= e1_nxt;
      s1_four_r <= in_ch.color_word[15:0] > in_ch.color_word[31:16];
      s1_cidx_r <= in_ch.color_word[63:32];
      s1_aw_r   <= in_ch.alpha_word;
    end
  end

  // ---------------------------------------------------------- palette stage
  always_comb begin
    rgb_t       m2, m3;
    logic [9:0] n2, n3;
    logic [7:0] a0, a1;
    logic [10:0] n7, n5;
    for (int k = 0; k < 3; k++) begin
      if (s1_four_r) begin
        n2 = {1'b0, s1_e0_r[k], 1'b0} + {2'b00, s1_e1_r[k]};
        n3 = {2'b00, s1_e0_r[k]} + {1'b0, s1_e1_r[k], 1'b0};
        m2[k] = div3(n2);
        m3[k] = div3(n3);
      end else begin
        n2 = {2'b00, s1_e0_r[k]} + {2'b00, s1_e1_r[k]};
        n3 = 10'd0;
        m2[k] = n2[8:1];
        m3[k] = 8'd0;
      end
    end
    cpal_nxt[0] = {8'hFF, s1_e0_r};
    cpal_nxt[1] = {8'hFF, s1_e1_r};
    cpal_nxt[2] = {8'hFF, m2};
    // three-color mode: index 3 is transparent black
    cpal_nxt[3] = s1_four_r ? {8'hFF, m3} : 32'd0;

    a0 = s1_aw_r[7:0];
    a1 = s1_aw_r[15:8];
    apal_nxt[0] = a0;
    apal_nxt[1] = a1;
    for (int i = 1; i < 7; i++) begin
      n7 = 11'(7 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1};
      n5 = (i < 5) ? 11'(5 - i) * {3'b000, a0} + 11'(i) * {3'b000, a1} : 11'd0;
      if (a0 > a1) begin
        apal_nxt[i + 1] = div7(n7);
      end else if (i < 5) begin
        apal_nxt[i + 1] = div5(n5);
      end else begin
        apal_nxt[i + 1] = (i == 5) ? 8'h00 : 8'hFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_cpal_r <= cpal_nxt;
      s2_apal_r <= apal_nxt;
      s2_cidx_r <= s1_cidx_r;
      s2_aw_r   <= s1_aw_r;
    end
  end

  // -------------------------------------------------------------- row stage
  always_comb begin
    logic [3:0]  pidx;
    logic [1:0]  ci;
    logic [3:0]  nib;
    logic [2:0]  ai;
    logic [5:0]  apos;
    logic [31:0] px;
    for (int x = 0; x < 4; x++) begin
      pidx = {s2_row_r, 2'(x)};
      ci   = s2_cidx_r[{pidx, 1'b0} +: 2];
      nib  = s2_aw_r[{pidx, 2'b00} +: 4];
      apos = 6'd16 + 6'(pidx) * 6'd3;
      ai   = s2_aw_r[apos +: 3];
      px   = s2_cpal_r[ci];
      case (fmt_r)
        FMT_DXT3: pix_nxt[x] = {nib, nib, px[23:0]};
        FMT_DXT5: pix_nxt[x] = {s2_apal_r[ai], px[23:0]};
        default:  pix_nxt[x] = px;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_row_r  <= s2_row_r;
      o_pix_r  <= pix_nxt;
      o_last_r <= (s2_row_r == 2'd3);
    end
  end

  assign out_ch.valid     = o_vld_r;
  assign out_ch.row_index = o_row_r;
  assign out_ch.pixel_a   = o_pix_r[0];
  assign out_ch.pixel_b   = o_pix_r[1];
  assign out_ch.pixel_c   = o_pix_r[2];
  assign out_ch.pixel_d   = o_pix_r[3];
  assign out_ch.last_row  = o_last_r;

`ifndef SYNTHESIS
  // never replace a block in the row stage before its last row leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load |-> (!s2_vld_r || s2_row_r == 2'd3))
    else $error("row stage reloaded mid-block");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_ch.valid && out_ch.row_index == $past(s2_row_r)))
    else $error("row beat out of order");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.last_row == (out_ch.row_index == 2'd3)))
    else $error("last_row does not match row_index");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take |=> s1_vld_r)
    else $error("accepted block lost at endpoint stage");
`endif

endmodule
